// ===== rtl/leb_pkg.sv =====
// Shared types and constants for the line edit buffer.
package leb_pkg;

    // Default number of character cells; the line holds one less.
    localparam int BUFFER_SIZE_DEF = 128;

    localparam int CHAR_W  = 8;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 8;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_REMOVE = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic              shift_right;
        logic              shift_left;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] ch;
    } cell_ctrl_t;

endpackage

// ===== rtl/line_edit_buffer_unit.sv =====
// Top level of the line edit buffer: control, cell chain and result register.
// Output: a result reaches the output register in the cycle after its transaction.
// Throughput: one transaction per cycle unless the result register is full and stalled; the
// whole tail moves in the chain at once, each cell loading from its left or right neighbor.
// Reset: rst_n (asynchronous, active low) empties the line and the result register;
// character cells are not reset, as no cell at or above the length is ever read.
module line_edit_buffer_unit
    import leb_pkg::*;
#(
    parameter int BUFFER_SIZE = BUFFER_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // op[2:0], ch[10:3], position[18:11], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[1:0], line_length[9:2], read_char[17:10], zero pad
);

    // Longest line the cells can hold.
    localparam logic [COUNT_W-1:0] CAP = COUNT_W'(BUFFER_SIZE - 1);

    // Input field unpacking.
    logic [2:0]        in_op;
    logic [CHAR_W-1:0] in_ch;
    logic [POS_W-1:0]  in_pos;

    assign in_op  = s_tdata[2:0];
    assign in_ch  = s_tdata[10:3];
    assign in_pos = s_tdata[18:11];

    // Line length and the result register.
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [1:0]         out_status_next;
    logic [CHAR_W-1:0]  out_char_reg;
    logic [CHAR_W-1:0]  out_char_next;

    logic accept;
    logic read_hit;

    cell_ctrl_t ctrl;

    // Chain wiring: each cell sees the characters of its two neighbors.
    logic [CHAR_W-1:0] cell_char [BUFFER_SIZE];
    logic [CHAR_W-1:0] cell_sel  [BUFFER_SIZE];
    logic [CHAR_W-1:0] read_or;

    // A new transaction is taken whenever the result register is free or drains now.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // A read only returns data from inside the line.
    assign read_hit = (in_op == OP_READ) && (in_pos < count_reg);

    // Decode the request into a length update, a status and the cell control.
    always_comb
    begin
        count_next       = count_reg;
        out_status_next  = ST_DONE;
        ctrl.shift_right = 1'b0;
        ctrl.shift_left  = 1'b0;
        ctrl.pos         = in_pos;
        ctrl.ch          = in_ch;
        unique case (in_op)
            OP_APPEND, OP_INSERT:
            begin
                if (count_reg >= CAP)
                begin
                    out_status_next = ST_FULL;
                end
                else if (in_ch != '0)
                begin
                    // Appending is an insert at the end; a position past the end
                    // also lands at the end.
                    if ((in_op == OP_APPEND) || (in_pos > count_reg))
                        ctrl.pos = count_reg;
                    ctrl.shift_right = accept;
                    count_next       = count_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (count_reg == '0)
                    out_status_next = ST_EMPTY;
                else
                    count_next = count_reg - 1'b1;
            end
            OP_DELETE:
            begin
                if (count_reg == '0)
                begin
                    out_status_next = ST_EMPTY;
                end
                else if (in_pos < count_reg)
                begin
                    ctrl.shift_left = accept;
                    count_next      = count_reg - 1'b1;
                end
            end
            default:
            begin
                // Read and the unused codes leave the line as it is.
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < BUFFER_SIZE; gi++)
        begin : g_cell
            logic [CHAR_W-1:0] left_c;
            logic [CHAR_W-1:0] right_c;

            if (gi == 0)
            begin : g_first
                assign left_c = in_ch;
            end
            else
            begin : g_mid_l
                assign left_c = cell_char[gi-1];
            end

            if (gi == BUFFER_SIZE - 1)
            begin : g_last
                assign right_c = '0;
            end
            else
            begin : g_mid_r
                assign right_c = cell_char[gi+1];
            end

            leb_cell #(
                .IDX(gi)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .left_char  (left_c),
                .right_char (right_c),
                .char_out   (cell_char[gi]),
                .sel_char   (cell_sel[gi])
            );
        end
    endgenerate

    // Only the cell whose index matches the position drives a nonzero value.
    always_comb
    begin
        read_or = '0;
        for (int i = 0; i < BUFFER_SIZE; i++)
            read_or = read_or | cell_sel[i];
    end

    assign out_char_next = read_hit ? read_or : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; it needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_status_reg <= out_status_next;
            out_char_reg   <= out_char_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_char_reg, count_reg, out_status_reg};

endmodule

// ===== rtl/leb_cell.sv =====
// One character cell of the line edit buffer chain.
module leb_cell
    import leb_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [CHAR_W-1:0] left_char,
    input  logic [CHAR_W-1:0] right_char,
    output logic [CHAR_W-1:0] char_out,
    output logic [CHAR_W-1:0] sel_char
);

    localparam logic [POS_W-1:0] IDX_B = POS_W'(IDX);

    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;

    // Insert: cells above the position take the left neighbor, the cell at the
    // position takes the new character. Delete: the position and above take the right.
    always_comb
    begin
        char_next = char_reg;
        if (ctrl.shift_right)
        begin
            if (IDX_B > ctrl.pos)
                char_next = left_char;
            else if (IDX_B == ctrl.pos)
                char_next = ctrl.ch;
        end
        else if (ctrl.shift_left)
        begin
            if (IDX_B >= ctrl.pos)
                char_next = right_char;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign char_out = char_reg;
    assign sel_char = (IDX_B == ctrl.pos) ? char_reg : '0;

endmodule
